>>> hw/rtl/flc_pkg.sv
// Shared types and codes of the FIFO lock coordinator.
package flc_pkg;

    // Field widths of the stream words
    localparam int ID_W      = 6;
    localparam int CHAN_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int GCOUNT_W  = 32;
    localparam int KNOWN_W   = 7;
    localparam int QLEN_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 64;

    // Largest id that the request word can carry, plus one
    localparam int ID_SPACE  = 64;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREE_REL   = 2'd2;

    // One waiting request in the queue memory
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [ID_W-1:0]   id;
    } flc_entry_t;

    // Result word, granted in bit 0
    typedef struct packed {
        logic [1:0]          pad;
        logic [STATUS_W-1:0] status;
        logic                lock_busy;
        logic [QLEN_W-1:0]   queue_length;
        logic [KNOWN_W-1:0]  known_count;
        logic [GCOUNT_W-1:0] grant_count;
        logic [CHAN_W-1:0]   grant_channel;
        logic [ID_W-1:0]     grant_id;
        logic                granted;
    } flc_result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic update;
    } flc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } flc_status_t;

endpackage

>>> hw/rtl/flc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/flc_ctrl.sv
// Controller state machine: sequences accept, lookup and update of one word.
module flc_ctrl
    import flc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output flc_cmd_t    cmd,
    input  flc_status_t sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Commit only once the result register can take the word
                if (sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/flc_datapath.sv
// Datapath: lock flag, wait queue, grant counters, known marks and result register.
module flc_datapath
    import flc_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int NUM_REQUESTERS = 64,
    parameter int COUNT_BITS     = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  flc_cmd_t            cmd,
    output flc_status_t         sts,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [ID_W-1:0]     in_id,
    input  logic [CHAN_W-1:0]   in_chan,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_DEPTH = (NUM_REQUESTERS < ID_SPACE) ? NUM_REQUESTERS : ID_SPACE;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int Q_AW      = $clog2(QUEUE_DEPTH);
    localparam int Q_FW      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [Q_AW-1:0]       Q_LAST  = Q_AW'(QUEUE_DEPTH - 1);
    localparam logic [Q_FW-1:0]       Q_FULL  = Q_FW'(QUEUE_DEPTH);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Word held between accept and update
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CHAN_W-1:0] chan_reg;

    // Lock and queue control state
    logic              busy_reg, busy_next;
    logic [Q_AW-1:0]   head_reg, head_next;
    logic [Q_AW-1:0]   tail_reg, tail_next;
    logic [Q_FW-1:0]   fill_reg, fill_next;
    logic [KNOWN_W-1:0] known_total_reg, known_total_next;
    logic [CNT_DEPTH-1:0] cnt_valid_reg, cnt_valid_next;

    // Counter address chosen in the lookup step
    logic [CNT_AW-1:0] cnt_idx_reg;
    logic              cnt_inr_reg;

    // Result register
    flc_result_t result_reg, result_next;
    logic        m_valid_reg, m_valid_next;

    // Memory ports
    flc_entry_t          q_wdata, q_rdata;
    logic                q_we;
    logic [ID_W-1:0]     sel_id;
    logic [CNT_AW-1:0]   sel_idx;
    logic [COUNT_BITS-1:0] cnt_rdata, cnt_cur, cnt_wdata;
    logic                cnt_we;
    logic                cnt_bump;

    // Update decode
    logic              grant_do;
    logic [ID_W-1:0]   grant_id;
    logic [CHAN_W-1:0] grant_chan;
    logic              q_push, q_pop;
    logic [STATUS_W-1:0] status;
    logic [COUNT_BITS-1:0] query_count;
    logic [CNT_AW-1:0] req_idx;
    logic              req_inr;
    logic              mark_new;

    // Queue memory: written at the tail, read at the head on accept
    flc_ram #(
        .WIDTH ($bits(flc_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .re    (cmd.accept),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // Grant counter memory: read in the lookup step, written on update
    flc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CNT_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_idx_reg),
        .wdata (cnt_wdata),
        .re    (cmd.lookup),
        .raddr (sel_idx),
        .rdata (cnt_rdata)
    );

    // A release looks up the head's counter, anything else the word's own id
    assign sel_id  = (func_reg == FUNC_RELEASE) ? q_rdata.id : id_reg;
    assign sel_idx = sel_id[CNT_AW-1:0];

    assign req_idx = id_reg[CNT_AW-1:0];
    assign req_inr = (32'(id_reg) < NUM_REQUESTERS);

    // A counter never written reads as zero. Every request writes its own
    // counter entry, so the valid bit of an entry also marks its id as known.
    assign cnt_cur = cnt_valid_reg[cnt_idx_reg] ? cnt_rdata : '0;

    // Operation decode for the update step
    always_comb begin
        grant_do    = 1'b0;
        grant_id    = '0;
        grant_chan  = '0;
        q_push      = 1'b0;
        q_pop       = 1'b0;
        status      = STATUS_OK;
        busy_next   = busy_reg;
        query_count = '0;
        mark_new    = 1'b0;
        unique case (func_reg)
            FUNC_REQUEST: begin
                mark_new = req_inr && !cnt_valid_reg[req_idx];
                if (!busy_reg) begin
                    busy_next  = 1'b1;
                    grant_do   = 1'b1;
                    grant_id   = id_reg;
                    grant_chan = chan_reg;
                end else if (fill_reg >= Q_FULL) begin
                    status = STATUS_QUEUE_FULL;
                end else begin
                    q_push = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                if (!busy_reg) begin
                    status = STATUS_FREE_REL;
                end else if (fill_reg == '0) begin
                    busy_next = 1'b0;
                end else begin
                    grant_do   = 1'b1;
                    grant_id   = q_rdata.id;
                    grant_chan = q_rdata.chan;
                    q_pop      = 1'b1;
                end
            end
            FUNC_QUERY: begin
                if (cnt_inr_reg) begin
                    query_count = cnt_cur;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory writes: a grant bumps the counter, a request rewrites its own entry
    assign q_wdata   = '{chan: chan_reg, id: id_reg};
    assign q_we      = cmd.update && q_push;
    assign cnt_bump  = grant_do && (cnt_cur != CNT_MAX);
    assign cnt_we    = cmd.update && cnt_inr_reg && (cnt_bump || (func_reg == FUNC_REQUEST));
    assign cnt_wdata = cnt_bump ? cnt_cur + 1'b1 : cnt_cur;

    // Next values of the control state
    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        known_total_next = known_total_reg;
        cnt_valid_next   = cnt_valid_reg;
        if (q_push) begin
            tail_next = (tail_reg == Q_LAST) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (q_pop) begin
            head_next = (head_reg == Q_LAST) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        if (mark_new) begin
            known_total_next = known_total_reg + 1'b1;
        end
        if (cnt_we) begin
            cnt_valid_next[cnt_idx_reg] = 1'b1;
        end
    end

    // Result word and its handshake
    always_comb begin
        result_next               = result_reg;
        result_next.pad           = '0;
        result_next.status        = status;
        result_next.lock_busy     = busy_next;
        result_next.queue_length  = QLEN_W'(fill_next);
        result_next.known_count   = known_total_next;
        result_next.grant_count   = GCOUNT_W'(query_count);
        result_next.grant_channel = grant_chan;
        result_next.grant_id      = grant_id;
        result_next.granted       = grant_do;

        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.update) begin
            m_valid_next = 1'b1;
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = result_reg;

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= in_func;
            id_reg   <= in_id;
            chan_reg <= in_chan;
        end
        if (cmd.lookup) begin
            cnt_idx_reg <= sel_idx;
            cnt_inr_reg <= (32'(sel_id) < NUM_REQUESTERS);
        end
        if (cmd.update) begin
            result_reg <= result_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
            known_total_reg <= '0;
            cnt_valid_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.update) begin
                busy_reg        <= busy_next;
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                fill_reg        <= fill_next;
                known_total_reg <= known_total_next;
                cnt_valid_reg   <= cnt_valid_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Waiting requests only exist while the lock is held.
    a_queue_needs_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0) |-> busy_reg)
        else $error("queue holds entries while the lock is free");

    // The queue never grows beyond its depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= Q_FULL)
        else $error("queue fill beyond depth");

    // An update is only issued when the result register can take it.
    a_update_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || m_tready))
        else $error("update would overwrite a waiting result");

    // Every update presents a result word in the next cycle.
    a_update_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid_reg)
        else $error("update did not present a result");

    // Known requesters never outnumber the counter slots.
    a_known_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(known_total_reg) <= CNT_DEPTH)
        else $error("known total beyond requester count");

endmodule

>>> hw/rtl/fifo_lock_coordinator.sv
// Top level of the FIFO lock coordinator: controller and datapath.
// Each input word passes the accept, lookup and update steps in order (queue head read
// on accept, counter read in lookup, result written on update).
// A new word is taken only after the last one's update, which waits while the result is not taken;
// the queue memory read must finish before the counter memory address is known.
// Reset (aresetn low, synchronous): lock free, queue empty, all counters and
// known marks cleared at once; queue memory contents are left as they are.
module fifo_lock_coordinator
    import flc_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int NUM_REQUESTERS = 64,
    parameter int COUNT_BITS     = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Request words
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // proc_id[5:0], reply_channel[13:6], zero[15:14]
    input  logic [FUNC_W-1:0]   s_tuser,  // func[1:0]
    // Result words
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // granted[0], grant_id[6:1], grant_channel[14:7],
                                          // grant_count[46:15], known_count[53:47],
                                          // queue_length[58:54], lock_busy[59],
                                          // status[61:60], zero[63:62]
);

    flc_cmd_t    cmd;
    flc_status_t sts;

    flc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    flc_datapath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_func  (s_tuser),
        .in_id    (s_tdata[ID_W-1:0]),
        .in_chan  (s_tdata[ID_W+CHAN_W-1:ID_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
